// File: design/assert_macros.svh
// Assertion macros used by the top level of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/ihex_pkg.sv
// Types, constants and character functions of the HEX record encoder.
package ihex_pkg;

  localparam int unsigned IDX_W = 4;

  localparam logic [IDX_W-1:0] DATA_LAST_IDX = 4'd13;
  localparam logic [IDX_W-1:0] EOF_LAST_IDX  = 4'd10;

  localparam logic [7:0] REC_PAYLOAD_LEN = 8'h01;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // One record as handed from the front to the back.
  typedef struct packed {
    logic        is_eof;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  chk;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {4'h0, n};
    end else begin
      c = 8'h57 + {4'h0, n};
    end
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] rec_last_idx(rec_t r);
    return r.is_eof ? EOF_LAST_IDX : DATA_LAST_IDX;
  endfunction

  function automatic out_word_t rec_char(rec_t r, logic [IDX_W-1:0] idx);
    out_word_t w;
    logic [7:0] c;
    c = CH_COLON;
    if (r.is_eof) begin
      unique case (idx) inside
        4'd0:                                      c = CH_COLON;
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: c = CH_ZERO;
        4'd8:                                      c = CH_ONE;
        4'd9, 4'd10:                               c = CH_F;
        default:                                   c = CH_COLON;
      endcase
    end else begin
      unique case (idx) inside
        4'd0:        c = CH_COLON;
        4'd1:        c = hex_digit(REC_PAYLOAD_LEN[7:4]);
        4'd2:        c = hex_digit(REC_PAYLOAD_LEN[3:0]);
        4'd3:        c = hex_digit(r.addr[15:12]);
        4'd4:        c = hex_digit(r.addr[11:8]);
        4'd5:        c = hex_digit(r.addr[7:4]);
        4'd6:        c = hex_digit(r.addr[3:0]);
        4'd7, 4'd8:  c = CH_ZERO;
        4'd9:        c = hex_digit(r.data[7:4]);
        4'd10:       c = hex_digit(r.data[3:0]);
        4'd11:       c = hex_digit(r.chk[7:4]);
        4'd12:       c = hex_digit(r.chk[3:0]);
        4'd13:       c = CH_NL;
        default:     c = CH_COLON;
      endcase
    end
    w.out_char  = c;
    w.last_char = (idx == rec_last_idx(r));
    return w;
  endfunction

endpackage

// File: design/ihex_front.sv
// Front end: accepts words, tracks the record address and builds record descriptors.
module ihex_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_push,
  input  ihex_pkg::in_word_t in_word,
  input  ihex_pkg::q_stat_t  q_stat,
  output logic               in_full,
  output logic               q_push,
  output ihex_pkg::rec_t     q_wrec
);
  import ihex_pkg::*;

  logic [15:0] start_addr_r, start_addr_nxt;
  logic [15:0] rec_addr_r, rec_addr_nxt;
  logic [7:0]  sum;

  assign in_full = q_stat.full;
  assign q_push  = in_push && !q_stat.full;

  always_comb begin
    sum = REC_PAYLOAD_LEN + rec_addr_r[7:0] + rec_addr_r[15:8] + in_word.data_byte;
    q_wrec.is_eof = (in_word.cmd == CMD_EOF);
    q_wrec.addr   = rec_addr_r;
    q_wrec.data   = in_word.data_byte;
    q_wrec.chk    = 8'h00 - sum;
  end

  always_comb begin
    start_addr_nxt = cfg_we ? cfg_wdata : start_addr_r;
    rec_addr_nxt   = rec_addr_r;
    if (q_push) begin
      rec_addr_nxt = (in_word.cmd == CMD_EOF) ? start_addr_r : rec_addr_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
      rec_addr_r   <= '0;
    end else begin
      start_addr_r <= start_addr_nxt;
      rec_addr_r   <= rec_addr_nxt;
    end
  end

endmodule

// File: design/ihex_queue.sv
// Two-entry record queue between the front end and the serializer.
module ihex_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ihex_pkg::rec_t    wrec,
  input  logic              pop,
  output ihex_pkg::rec_t    rrec,
  output ihex_pkg::q_stat_t stat
);
  import ihex_pkg::*;

  rec_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rrec       = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wrec;
    end
  end

endmodule

// File: design/ihex_back.sv
// Back end: serializes the head record, one word per cycle unless stalled.
module ihex_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ihex_pkg::rec_t      q_rrec,
  input  ihex_pkg::q_stat_t   q_stat,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output ihex_pkg::out_word_t out_word
);
  import ihex_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  out_word_t        ow_r, ow_nxt;
  logic             load;

  // A queued record loads its next character when the output is free or popped.
  assign load      = !q_stat.empty && (!ov_r || out_pop);
  assign q_pop     = load && ow_nxt.last_char;
  assign out_empty = !ov_r;
  assign out_word  = ow_r;

  always_comb begin
    ow_nxt  = rec_char(q_rrec, idx_r);
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = ow_nxt.last_char ? '0 : idx_r + IDX_W'(1);
    end
    ov_nxt = load ? 1'b1 : (out_pop ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ow_r <= ow_nxt;
    end
  end

endmodule

// File: design/intel_hex_record_encoder_unit.sv
// Top level of the HEX record encoder: front end, record queue and serializer.
// Input words carry a command and a data byte. A data command produces one
// 14-character data record, an end-of-file command the 11-character record
// ":00000001ff" and reloads the record address from the start address.
// A word is accepted on an edge with in_push high and in_full low; characters
// leave on an edge with out_pop high and out_empty low, last_char marking the
// final character of each record. The start address is written through cfg_we
// and cfg_wdata and takes effect at the next end-of-file command; reset clears it.
// A word accepted into an idle block is stored in a queue entry and then loaded
// into the output register, after which its first character can be popped.
// Throughput is one character per cycle while the receiver keeps popping, set by
// the single output register of the serializer. A two-entry queue lets words be
// accepted while earlier records are still being sent. When the receiver stalls,
// the current character holds, the queue fills and in_full rises. Synchronous
// reset empties the queue and the output and clears both addresses to zero.
`include "assert_macros.svh"

module intel_hex_record_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_push,
  input  ihex_pkg::in_word_t  in_word,
  output logic                in_full,
  input  logic                out_pop,
  output logic                out_empty,
  output ihex_pkg::out_word_t out_word
);
  import ihex_pkg::*;

  logic    q_push;
  logic    q_pop;
  rec_t    q_wrec;
  rec_t    q_rrec;
  q_stat_t q_stat;
  logic    out_is_last;
  logic    out_end_code;
  logic    idle_push;
  logic    first_colon;

  ihex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_word   (in_word),
    .q_stat    (q_stat),
    .in_full   (in_full),
    .q_push    (q_push),
    .q_wrec    (q_wrec)
  );

  ihex_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wrec  (q_wrec),
    .pop   (q_pop),
    .rrec  (q_rrec),
    .stat  (q_stat)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rrec    (q_rrec),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

  assign out_is_last  = !out_empty && out_word.last_char;
  assign out_end_code = (out_word.out_char == CH_NL) || (out_word.out_char == CH_F);
  assign idle_push    = in_push && !in_full && out_empty && q_stat.empty;
  assign first_colon  = !out_empty && (out_word.out_char == CH_COLON);

  // The end of a record is always a newline or the closing digit of end-of-file.
  `ASSERT_CLK(a_last_char_code, out_is_last |-> out_end_code, "record ends on a wrong character")

  // Reset leaves no character waiting.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty, "output not empty after reset")

  // A word taken into an idle block has its first character, a colon, ready to pop
  `ASSERT_CLK(a_idle_latency, idle_push |-> ##2 first_colon, "first character late or wrong")

endmodule

// File: bench/tb_top.sv
// Testbench for the HEX record encoder: directed table, random bursts, character scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import ihex_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_SPARSE, POP_BURSTY} pop_mode_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [7:0]  data;
    logic [15:0] addr;
    string       rec;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;
  logic        in_push = 1'b0;
  in_word_t    in_word = '0;
  logic        in_full;
  logic        out_pop = 1'b0;
  logic        out_empty;
  out_word_t   out_word;

  // Model state, owned by the scoreboard process.
  logic [15:0] model_start = 16'h0000;
  logic [15:0] model_addr = 16'h0000;

  out_word_t   pending_chars[$];
  string       literal_recs[$];
  row_t        directed_rows[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned pop_tick = 0;
  pop_mode_t   pop_mode = POP_ALWAYS;

  always #6 clk = ~clk;

  intel_hex_record_encoder_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_word (out_word)
  );

  // Builds the text of the record for one word and advances the record address.
  function automatic string encode_record(logic cmd, logic [7:0] data);
    logic [7:0] chk;
    string      s;
    if (cmd == CMD_EOF) begin
      model_addr = model_start;
      return ":00000001ff";
    end
    chk = 8'h00 - (REC_PAYLOAD_LEN + model_addr[7:0] + model_addr[15:8] + data);
    s = $sformatf(":%02h%04h00%02h%02h\n", REC_PAYLOAD_LEN, model_addr, data, chk);
    model_addr = model_addr + 16'd1;
    return s;
  endfunction

  always @(posedge clk) begin : scoreboard
    string     rec;
    string     predicted;
    out_word_t want;
    int        k;
    if (rst_n) begin
      if (cfg_we) begin
        model_start = cfg_wdata;
      end
      if (out_pop && !out_empty) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected word: out_char %02h last_char %0b",
                 out_word.out_char, out_word.last_char);
          fail_count++;
        end else begin
          want = pending_chars.pop_front();
          if (out_word.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, out_word.out_char);
            fail_count++;
          end
          if (out_word.last_char !== want.last_char) begin
            $error("last_char: expected %0b, got %0b", want.last_char, out_word.last_char);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) begin
        predicted = encode_record(in_word.cmd, in_word.data_byte);
        rec = "";
        if (literal_recs.size() != 0) begin
          rec = literal_recs.pop_front();
        end
        // A row with the record typed in is checked against that text.
        if (rec.len() == 0) begin
          rec = predicted;
        end
        for (k = 0; k < rec.len(); k++) begin
          want.out_char  = rec[k];
          want.last_char = (k == rec.len() - 1);
          pending_chars.push_back(want);
        end
      end
    end
  end

  // The receiver pops on a random pattern, chosen anew whenever pop_tick[6:0] is zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      pop_tick <= pop_tick + 1;
      if (pop_tick[6:0] == 7'd0) begin
        pop_mode <= pop_mode_t'($urandom_range(0, 3));
      end
      case (pop_mode)
        POP_ALWAYS: out_pop <= 1'b1;
        POP_RANDOM: out_pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: out_pop <= (pop_tick % 9 == 0);
        default:    out_pop <= pop_tick[3];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_push && !in_full) || (out_pop && !out_empty))) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic add_row(row_kind_t kind, logic cmd, logic [7:0] data, logic [15:0] addr,
                         string rec);
    row_t r;
    r.kind = kind;
    r.cmd  = cmd;
    r.data = data;
    r.addr = addr;
    r.rec  = rec;
    directed_rows.push_back(r);
  endtask

  // Offers one word and returns at the edge where it is taken; push stays high.
  task automatic send_word(logic cmd, logic [7:0] data, string rec);
    in_word_t w;
    w.cmd       = cmd;
    w.data_byte = data;
    literal_recs.push_back(rec);
    in_word <= w;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles != 0) begin
      in_push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(logic [15:0] addr);
    drain();
    cfg_wdata <= addr;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [15:0] phase_starts[6];
    int unsigned sent;
    int unsigned burst;
    logic        cmd;

    add_row(ROW_WORD, CMD_DATA, 8'h00, 16'h0000, ":0100000000ff\n");
    add_row(ROW_WORD, CMD_DATA, 8'hff, 16'h0000, ":01000100ffff\n");
    add_row(ROW_WORD, CMD_EOF,  8'h00, 16'h0000, ":00000001ff");
    add_row(ROW_CFG,  CMD_DATA, 8'h00, 16'hffff, "");
    add_row(ROW_WORD, CMD_EOF,  8'h00, 16'h0000, ":00000001ff");
    add_row(ROW_WORD, CMD_DATA, 8'ha5, 16'h0000, ":01ffff00a55c\n");
    // The address has wrapped to zero here with no extended record.
    add_row(ROW_WORD, CMD_DATA, 8'h5a, 16'h0000, "");
    add_row(ROW_WORD, CMD_DATA, 8'h0f, 16'h0000, "");
    add_row(ROW_WORD, CMD_DATA, 8'hf0, 16'h0000, "");
    add_row(ROW_WORD, CMD_EOF,  8'hff, 16'h0000, ":00000001ff");
    add_row(ROW_WORD, CMD_DATA, 8'h00, 16'h0000, ":01ffff000001\n");
    // A new start address must not move the current record address.
    add_row(ROW_CFG,  CMD_DATA, 8'h00, 16'h8000, "");
    add_row(ROW_WORD, CMD_DATA, 8'h80, 16'h0000, ":01000000807f\n");
    add_row(ROW_WORD, CMD_EOF,  8'h00, 16'h0000, "");
    add_row(ROW_WORD, CMD_DATA, 8'h7f, 16'h0000, "");
    add_row(ROW_WORD, CMD_DATA, 8'h3c, 16'h0000, "");
    add_row(ROW_CFG,  CMD_DATA, 8'h00, 16'h0000, "");
    add_row(ROW_WORD, CMD_EOF,  8'h00, 16'h0000, "");
    add_row(ROW_WORD, CMD_DATA, 8'h01, 16'h0000, ":0100000001fe\n");
    add_row(ROW_WORD, CMD_DATA, 8'h55, 16'h0000, "");

    phase_starts = '{16'hffff, 16'h0000, 16'hfff0, 16'($urandom), 16'($urandom), 16'h7fff};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_start(directed_rows[i].addr);
      end else begin
        send_word(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].rec);
        pause_sender($urandom_range(0, 2));
      end
    end

    foreach (phase_starts[p]) begin
      write_start(phase_starts[p]);
      send_word(CMD_EOF, 8'($urandom), "");
      sent = 0;
      while (sent < 44) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          cmd = ($urandom_range(0, 15) == 0) ? CMD_EOF : CMD_DATA;
          send_word(cmd, 8'($urandom), "");
          sent++;
        end
        // Let everything drain once in the middle of a phase.
        if (p == 2 && sent >= 22 && sent < 22 + burst) begin
          drain();
        end else if ($urandom_range(0, 3) == 0) begin
          pause_sender(0);
        end else begin
          pause_sender($urandom_range(1, 25));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/ihex_pkg.sv
design/ihex_front.sv
design/ihex_queue.sv
design/ihex_back.sv
design/intel_hex_record_encoder_unit.sv
bench/tb_top.sv
